FILE: rtl/process_table_scheduler_core_macros.svh
// Assertion macros shared by the scheduler RTL.
// Expects clk and rst_n in the scope of use.
`ifndef PROCESS_TABLE_SCHEDULER_CORE_MACROS_SVH
`define PROCESS_TABLE_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication.
`define PTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pts_pkg.sv
// Types, codes and constants of the process table scheduler.
// No dependencies; used by the core, pts_mem and pts_div.
`default_nettype none
package pts_pkg;

  localparam int DEF_TABLE_DEPTH = 16;
  localparam int DIV_W           = 33;  // dividend width of the shared divider
  localparam int DVS_W           = 16;  // divisor width

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_RR   = 3'd1;
  localparam logic [2:0] POL_SJN  = 3'd2;
  localparam logic [2:0] POL_SRT  = 3'd3;
  localparam logic [2:0] POL_HRRN = 3'd4;

  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_RAN      = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_ZERO_EXE = 3'd4;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arr;
    logic [15:0] exec;
    logic [15:0] prog;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/pts_chan_if.sv
// Valid/ready channel interfaces for scheduler items and results.
// No dependencies.
`default_nettype none
interface pts_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  proc_id;
  logic [31:0] arrival_time;
  logic [15:0] exec_time;
  modport source (output valid, mode, proc_id, arrival_time, exec_time, input ready);
  modport sink   (input valid, mode, proc_id, arrival_time, exec_time, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  ran_id;
  logic [15:0] run_amount;
  logic        finished;
  logic [31:0] turnaround;
  logic [31:0] system_time;
  modport source (output valid, status, ran_id, run_amount, finished, turnaround,
                  system_time, input ready);
  modport sink   (input valid, status, ran_id, run_amount, finished, turnaround,
                  system_time, output ready);
endinterface
`default_nettype wire

FILE: rtl/process_table_scheduler_core.sv
// Channel     | Dir | Handshake      | Payload
// in_ch       | in  | valid/ready    | mode, proc_id, arrival_time, exec_time
// out_ch      | out | valid/ready    | status, ran_id, run_amount, finished, turnaround,
//             |     |                |   system_time
// cfg_*       | in  | write enable   | cfg_index (0 policy, 1 quantum), cfg_wdata
// One item at a time. An add writes the new entry at the back; a FCFS step runs the
// head entry and a SJN/SRT step first scans every entry, plus a shift of each later
// entry on removal and a write to the back on rotation; round robin first takes a
// modulo in the shared divider, and response ratio divides each entry in it.
// Every read goes through the single table read port, which is registered.
// Reset is synchronous and empties the table; no clearing pass is needed.
// A stalled result holds the finished item in its last state; in_ch is not
// ready again until that result is loaded into the output register.
// Depends on pts_pkg, pts_chan_if, pts_mem, pts_div and the macros header.
`default_nettype none
module process_table_scheduler_core #(
  parameter int TABLE_DEPTH = pts_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  pts_in_if.sink      in_ch,
  pts_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import pts_pkg::*;
  `include "process_table_scheduler_core_macros.svh"

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_RR, S_SC_RD, S_SC_CMP, S_SC_DIV, S_FETCH, S_EXEC,
    S_SH_RD, S_SH_WR, S_ROT_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  ran_id;
    logic [15:0] run_amount;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] system_time;
  } res_t;

  state_t           state_r;
  logic [2:0]       policy_r;
  logic [15:0]      quantum_r;
  logic [OCC_W-1:0] occ_r, idx_r, occ_m1;
  logic [IDX_W-1:0] sel_r;
  logic [31:0]      clock_r, rot_r;
  logic [DIV_W-1:0] best_r;
  entry_t           ent_r;
  logic             rotate_r;
  res_t             res_r, out_r;
  logic             out_valid_r;
  logic             out_load;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic             in_acc;
  logic [15:0]      rem, grant, new_prog;
  logic             fin, rot;
  logic [31:0]      clk_new, wait_t;
  logic [15:0]      div_s;
  logic [DIV_W-1:0] key;
  logic [OCC_W-1:0] idx_inc, sel_inc;

  pts_mem #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  pts_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign occ_m1      = occ_r - 1'b1;
  assign idx_inc     = idx_r + 1'b1;
  assign sel_inc     = OCC_W'(sel_r) + 1'b1;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  // Decision on the selected entry, valid in S_EXEC.
  always_comb begin
    rem      = (mem_rdata.exec > mem_rdata.prog) ? mem_rdata.exec - mem_rdata.prog : '0;
    grant    = rem;
    new_prog = mem_rdata.prog;
    fin      = 1'b1;
    rot      = 1'b0;
    unique case (policy_r)
      POL_RR: begin
        grant    = (quantum_r < rem) ? quantum_r : rem;
        new_prog = mem_rdata.prog + grant;
        fin      = (grant == rem);
        rot      = !fin;
      end
      POL_SRT: begin
        grant    = {15'd0, rem != 16'd0};
        new_prog = mem_rdata.prog + grant;
        fin      = !(mem_rdata.exec > new_prog);
      end
      default: begin
      end
    endcase
    clk_new = clock_r + 32'(grant);
  end

  // Scan keys.
  always_comb begin
    wait_t = (clock_r >= mem_rdata.arr) ? clock_r - mem_rdata.arr : '0;
    div_s  = (mem_rdata.exec != 16'd0) ? mem_rdata.exec : 16'd1;
    key    = (policy_r == POL_SJN) ? DIV_W'(mem_rdata.exec) : DIV_W'(rem);
  end

  always_comb begin
    div_req = '0;
    if (state_r == S_IDLE && in_acc && in_ch.mode && occ_r != '0 && policy_r == POL_RR) begin
      div_req.start    = 1'b1;
      div_req.dividend = DIV_W'(rot_r);
      div_req.divisor  = DVS_W'(occ_r);
    end else if (state_r == S_SC_CMP && policy_r == POL_HRRN) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, wait_t} + DIV_W'(div_s);
      div_req.divisor  = div_s;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sel_r;
    mem_wdata = mem_rdata;
    mem_raddr = sel_r;
    unique case (state_r)
      S_IDLE: begin
        mem_waddr = occ_r[IDX_W-1:0];
        mem_wdata = '{id: in_ch.proc_id, arr: in_ch.arrival_time,
                      exec: in_ch.exec_time, prog: 16'd0};
        mem_we    = in_acc && !in_ch.mode && in_ch.exec_time != 16'd0 &&
                    occ_r < OCC_W'(TABLE_DEPTH);
      end
      S_SC_RD:  mem_raddr = idx_r[IDX_W-1:0];
      S_EXEC: begin
        mem_wdata.prog = new_prog;
        mem_we         = !fin && !rot;
      end
      S_SH_RD:  mem_raddr = idx_inc[IDX_W-1:0];
      S_SH_WR: begin
        mem_waddr = idx_r[IDX_W-1:0];
        mem_we    = 1'b1;
      end
      S_ROT_WR: begin
        mem_waddr = occ_m1[IDX_W-1:0];
        mem_wdata = ent_r;
        mem_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      policy_r    <= POL_FCFS;
      quantum_r   <= 16'd1;
      occ_r       <= '0;
      clock_r     <= '0;
      rot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POLICY:  policy_r  <= cfg_wdata[2:0];
          CFG_QUANTUM: quantum_r <= cfg_wdata;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_r.ran_id      <= '0;
            res_r.run_amount  <= '0;
            res_r.finished    <= 1'b0;
            res_r.turnaround  <= '0;
            res_r.system_time <= clock_r;
            sel_r       <= '0;
            idx_r       <= '0;
            best_r      <= '0;
            if (!in_ch.mode) begin
              state_r <= S_DONE;
              if (in_ch.exec_time == 16'd0) begin
                res_r.status <= ST_ZERO_EXE;
              end else if (occ_r >= OCC_W'(TABLE_DEPTH)) begin
                res_r.status <= ST_FULL;
              end else begin
                res_r.status <= ST_ADDED;
                occ_r        <= occ_r + 1'b1;
              end
            end else if (occ_r == '0) begin
              res_r.status <= ST_EMPTY;
              state_r      <= S_DONE;
            end else begin
              priority case (policy_r)
                POL_RR:                    state_r <= S_DIV_RR;
                POL_SJN, POL_SRT, POL_HRRN: state_r <= S_SC_RD;
                default:                   state_r <= S_FETCH;
              endcase
            end
          end
        end
        S_DIV_RR: begin
          if (div_rsp.done) begin
            sel_r   <= div_rsp.rem[IDX_W-1:0];
            state_r <= S_FETCH;
          end
        end
        S_SC_RD: state_r <= S_SC_CMP;
        S_SC_CMP: begin
          if (policy_r == POL_HRRN) begin
            state_r <= S_SC_DIV;
          end else begin
            if (idx_r == '0 || key < best_r) begin
              best_r <= key;
              sel_r  <= idx_r[IDX_W-1:0];
            end
            idx_r   <= idx_inc;
            state_r <= (idx_inc < occ_r) ? S_SC_RD : S_FETCH;
          end
        end
        S_SC_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.quo > best_r) begin
              best_r <= div_rsp.quo;
              sel_r  <= idx_r[IDX_W-1:0];
            end
            idx_r   <= idx_inc;
            state_r <= (idx_inc < occ_r) ? S_SC_RD : S_FETCH;
          end
        end
        S_FETCH: state_r <= S_EXEC;
        S_EXEC: begin
          ent_r      <= '{id: mem_rdata.id, arr: mem_rdata.arr,
                          exec: mem_rdata.exec, prog: new_prog};
          rotate_r   <= rot;
          clock_r    <= clk_new;
          if (policy_r == POL_RR) begin
            rot_r <= rot_r + 32'd1;
          end
          res_r.status      <= ST_RAN;
          res_r.ran_id      <= mem_rdata.id;
          res_r.run_amount  <= grant;
          res_r.finished    <= fin;
          res_r.turnaround  <= clk_new - mem_rdata.arr;
          res_r.system_time <= clk_new;
          idx_r             <= OCC_W'(sel_r);
          if (fin || rot) begin
            if (sel_inc < occ_r) begin
              state_r <= S_SH_RD;
            end else if (rot) begin
              state_r <= S_ROT_WR;
            end else begin
              occ_r   <= occ_m1;
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_SH_RD: state_r <= S_SH_WR;
        S_SH_WR: begin
          idx_r <= idx_inc;
          if ((idx_inc + 1'b1) < occ_r) begin
            state_r <= S_SH_RD;
          end else if (rotate_r) begin
            state_r <= S_ROT_WR;
          end else begin
            occ_r   <= occ_m1;
            state_r <= S_DONE;
          end
        end
        S_ROT_WR: state_r <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            out_r   <= res_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_r.status;
  assign out_ch.ran_id      = out_r.ran_id;
  assign out_ch.run_amount  = out_r.run_amount;
  assign out_ch.finished    = out_r.finished;
  assign out_ch.turnaround  = out_r.turnaround;
  assign out_ch.system_time = out_r.system_time;

  `PTS_ASSERT_IMPL(a_occ_bound, 1'b1, occ_r <= OCC_W'(TABLE_DEPTH), "occupancy over depth")
  `PTS_ASSERT_NEXT(a_add_grows, in_acc && !in_ch.mode && in_ch.exec_time != 16'd0 && occ_r < OCC_W'(TABLE_DEPTH), occ_r == $past(occ_r) + 1'b1, "add did not grow table")
  `PTS_ASSERT_IMPL(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `PTS_ASSERT_IMPL(a_out_from_done, $rose(out_valid_r), $past(state_r == S_DONE), "result outside done state")

endmodule
`default_nettype wire

FILE: rtl/pts_mem.sv
// Process table storage: one write port, one read port, registered read.
// Depends on pts_pkg.
`default_nettype none
module pts_mem #(
  parameter int TABLE_DEPTH = pts_pkg::DEF_TABLE_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  pts_pkg::entry_t    wdata,
  input  logic [IDX_W-1:0]   raddr,
  output pts_pkg::entry_t    rdata
);
  import pts_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/pts_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pts_pkg.
`default_nettype none
module pts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pts_pkg::div_req_t req,
  output pts_pkg::div_rsp_t rsp
);
  import pts_pkg::*;

  logic [DIV_W-1:0] q_r;
  logic [DVS_W-1:0] r_r, d_r;
  logic [5:0]       cnt_r;
  logic             busy_r, done_r;
  logic [DVS_W:0]   shifted, diff;
  logic             ge;

  always_comb begin
    shifted = {r_r, q_r[DIV_W-1]};
    ge      = shifted >= {1'b0, d_r};
    diff    = shifted - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r <= req.dividend;
      r_r <= '0;
      d_r <= req.divisor;
    end else if (busy_r) begin
      q_r <= {q_r[DIV_W-2:0], ge};
      r_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = r_r;

endmodule
`default_nettype wire
